// ===== rtl/windowed_throughput_meter_macros.svh =====
// Assertion macros shared by the throughput meter modules.
`ifndef WINDOWED_THROUGHPUT_METER_MACROS_SVH
`define WINDOWED_THROUGHPUT_METER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define WTM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("throughput meter check failed");

// Next-cycle implication, checked outside reset
`define WTM_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("throughput meter check failed");

`endif

// ===== rtl/wtm_pkg.sv =====
// Shared types and constants for the windowed throughput meter.
package wtm_pkg;

  localparam int TS_W         = 48;
  localparam int POS_W        = 48;
  localparam int RATE_W       = 58;
  localparam int INTERVAL_W   = 16;
  localparam int IN_TDATA_W   = 96;
  localparam int OUT_TDATA_W  = 64;
  localparam int DIV_CNT_W    = $clog2(RATE_W + 1);

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;

  // 1000 = 1024 - 16 - 8, applied as shifts
  localparam int MS_SHIFT_HI  = 10;
  localparam int MS_SHIFT_MID = 4;
  localparam int MS_SHIFT_LO  = 3;

  // One stored ring sample
  typedef struct packed {
    logic [TS_W-1:0]  ts;
    logic [POS_W-1:0] pos;
  } sample_t;

  // Item sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_ADDR,
    S_DIFF,
    S_MUL_A,
    S_MUL_B,
    S_DIV,
    S_LOAD
  } state_t;

endpackage

// ===== rtl/wtm_ring.sv =====
// Sample ring memory: one write port, one registered read port.
module wtm_ring #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  wtm_pkg::sample_t             wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output wtm_pkg::sample_t             rd_data
);

  wtm_pkg::sample_t mem [DEPTH];
  wtm_pkg::sample_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/wtm_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
`include "windowed_throughput_meter_macros.svh"

module wtm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [wtm_pkg::RATE_W-1:0]   dividend,
  input  logic [wtm_pkg::TS_W-1:0]     divisor,
  output logic                         busy,
  output logic                         done,
  output logic [wtm_pkg::RATE_W-1:0]   quotient
);

  logic [wtm_pkg::TS_W-1:0]      rem_r;
  logic [wtm_pkg::RATE_W-1:0]    quo_r;
  logic [wtm_pkg::TS_W-1:0]      dvs_r;
  logic [wtm_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;

  logic [wtm_pkg::TS_W:0]        shifted;
  logic [wtm_pkg::TS_W+1:0]      trial;
  logic                          q_bit;
  logic [wtm_pkg::TS_W-1:0]      rem_nxt;

  // One restoring step: bring in the next dividend bit, try the subtract
  always_comb begin
    shifted = {rem_r, quo_r[wtm_pkg::RATE_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_r};
    q_bit   = ~trial[wtm_pkg::TS_W+1];
    rem_nxt = q_bit ? trial[wtm_pkg::TS_W-1:0] : shifted[wtm_pkg::TS_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= wtm_pkg::DIV_CNT_W'(wtm_pkg::RATE_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == wtm_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift registers for remainder and dividend/quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[wtm_pkg::RATE_W-2:0], q_bit};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

  `WTM_ASSERT_IMP(a_start_idle, clk, rst_n, start, !busy_r)
  `WTM_ASSERT_IMP(a_done_idle, clk, rst_n, done_r, !busy_r)
  `WTM_ASSERT_IMP(a_busy_count, clk, rst_n, busy_r, cnt_r != '0)

endmodule

// ===== rtl/windowed_throughput_meter.sv =====
// Windowed throughput meter top level: sequencer, sample registers, output stage.
//
// Input channel (in_*): each transaction carries a millisecond timestamp and a
// byte position. The first item after reset is always stored in the sample
// ring; later ones are stored only when cfg interval milliseconds have passed
// since the newest stored sample. Every item gives exactly one result on the
// output channel (out_*): the rate in bytes per second between the oldest and
// newest ring samples (zero with fewer than two samples or a zero time span),
// and in out_tuser a flag set when the item was stored.
// Path from input acceptance to out_tvalid: store decision, ring read,
// differences and times-1000, then the bit-serial divider (one quotient bit
// per cycle), then the hand-over to the output register. Items with a zero
// rate skip the divider. One item is in work at a time and in_tready rises in
// the same cycle as the result reaches the output register, so a new item is
// taken only after the last result has been loaded.
// Reset (rst_n low, synchronous) empties the ring, sets the interval to 1000 ms
// and drops out_tvalid. If the receiver stalls, the result holds in the output
// register; one further item may be worked, then it waits for the register.
// cfg_wr_en writes the interval; write only while no item is in work.
`include "windowed_throughput_meter_macros.svh"

module windowed_throughput_meter #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Interval register write
  input  logic                                cfg_wr_en,
  input  logic [wtm_pkg::INTERVAL_W-1:0]      cfg_wr_data,  // sample_interval_ms
  // Input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [wtm_pkg::IN_TDATA_W-1:0]      in_tdata,     // timestamp_ms, position
  // Result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [wtm_pkg::OUT_TDATA_W-1:0]     out_tdata,    // rate_bytes_per_sec, zero pad
  output logic                                out_tuser     // sample_stored
);

  localparam int SLOT_W  = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W   = $clog2(2 * DEPTH + 1);

  wtm_pkg::state_t state_r, state_nxt;

  // Control state
  logic [wtm_pkg::INTERVAL_W-1:0] interval_r;
  logic [SLOT_W-1:0]              newest_slot_r;
  logic [COUNT_W-1:0]             count_r;
  logic                           out_tvalid_r;

  // Payload registers
  logic [wtm_pkg::TS_W-1:0]       ts_r;
  logic [wtm_pkg::POS_W-1:0]      pos_r;
  logic [wtm_pkg::TS_W-1:0]       newest_ts_r;
  logic [wtm_pkg::POS_W-1:0]      newest_pos_r;
  logic                           stored_r;
  logic [wtm_pkg::POS_W-1:0]      dpos_r;
  logic [wtm_pkg::TS_W-1:0]       dtime_r;
  logic                           zero_r;
  logic [wtm_pkg::RATE_W-1:0]     prod_r;
  logic [wtm_pkg::RATE_W-1:0]     rate_r;
  logic                           out_stored_r;

  // Sequencer outputs
  logic                           in_accept;
  logic                           out_free;
  logic                           ring_wr;
  logic                           ring_rd;
  logic                           div_start;
  logic                           out_load;

  // Datapath signals
  logic [wtm_pkg::TS_W-1:0]       elapsed;
  logic                           store;
  logic [SLOT_W-1:0]              next_slot;
  logic [SLOT_W-1:0]              store_slot;
  logic [SUM_W-1:0]               oldest_sum;
  logic [SLOT_W-1:0]              oldest_slot;
  wtm_pkg::sample_t               wr_sample;
  wtm_pkg::sample_t               rd_sample;
  logic                           div_busy;
  logic                           div_done;
  logic [wtm_pkg::RATE_W-1:0]     div_q;

  assign in_accept = in_tvalid & in_tready;
  assign out_free  = ~out_tvalid_r | out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wtm_pkg::S_IDLE:   if (in_tvalid) state_nxt = wtm_pkg::S_DECIDE;
      wtm_pkg::S_DECIDE: state_nxt = wtm_pkg::S_ADDR;
      wtm_pkg::S_ADDR:   state_nxt = wtm_pkg::S_DIFF;
      wtm_pkg::S_DIFF:   state_nxt = wtm_pkg::S_MUL_A;
      wtm_pkg::S_MUL_A:  state_nxt = wtm_pkg::S_MUL_B;
      wtm_pkg::S_MUL_B:  state_nxt = zero_r ? wtm_pkg::S_LOAD : wtm_pkg::S_DIV;
      wtm_pkg::S_DIV:    if (div_done) state_nxt = wtm_pkg::S_LOAD;
      wtm_pkg::S_LOAD:   if (out_free) state_nxt = wtm_pkg::S_IDLE;
      default:           state_nxt = wtm_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs; the divider starts on entry to S_DIV, once the product is final
  always_comb begin
    in_tready = 1'b0;
    ring_wr   = 1'b0;
    ring_rd   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      wtm_pkg::S_IDLE:   in_tready = 1'b1;
      wtm_pkg::S_DECIDE: ring_wr   = store;
      wtm_pkg::S_ADDR:   ring_rd   = 1'b1;
      wtm_pkg::S_DIV:    div_start = ~div_busy & ~div_done;
      wtm_pkg::S_LOAD:   out_load  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wtm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Interval register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= wtm_pkg::INTERVAL_RESET;
    end else if (cfg_wr_en) begin
      interval_r <= cfg_wr_data;
    end
  end

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ts_r  <= in_tdata[wtm_pkg::TS_W-1:0];
      pos_r <= in_tdata[wtm_pkg::TS_W +: wtm_pkg::POS_W];
    end
  end

  // Store decision against the newest sample
  always_comb begin
    elapsed    = ts_r - newest_ts_r;
    store      = (count_r == '0) ||
                 (elapsed >= {{(wtm_pkg::TS_W - wtm_pkg::INTERVAL_W){1'b0}}, interval_r});
    next_slot  = (newest_slot_r == SLOT_W'(DEPTH - 1)) ? '0 : newest_slot_r + 1'b1;
    store_slot = (count_r == '0) ? newest_slot_r : next_slot;
    wr_sample  = '{ts: ts_r, pos: pos_r};
  end

  // Ring pointers and newest-sample copy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_slot_r <= '0;
      count_r       <= '0;
    end else if (ring_wr) begin
      newest_slot_r <= store_slot;
      if (count_r != COUNT_W'(DEPTH)) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == wtm_pkg::S_DECIDE) begin
      stored_r <= store;
    end
    if (ring_wr) begin
      newest_ts_r  <= ts_r;
      newest_pos_r <= pos_r;
    end
  end

  // Oldest valid slot: newest + 1 - count, modulo DEPTH
  always_comb begin
    oldest_sum = SUM_W'(newest_slot_r) + SUM_W'(DEPTH + 1) - SUM_W'(count_r);
    if (oldest_sum >= SUM_W'(DEPTH)) begin
      oldest_slot = SLOT_W'(oldest_sum - SUM_W'(DEPTH));
    end else begin
      oldest_slot = SLOT_W'(oldest_sum);
    end
  end

  wtm_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr),
    .wr_addr (store_slot),
    .wr_data (wr_sample),
    .rd_en   (ring_rd),
    .rd_addr (oldest_slot),
    .rd_data (rd_sample)
  );

  // Window differences, then position difference times 1000 in two steps
  always_ff @(posedge clk) begin
    if (state_r == wtm_pkg::S_DIFF) begin
      dpos_r  <= newest_pos_r - rd_sample.pos;
      dtime_r <= newest_ts_r - rd_sample.ts;
      zero_r  <= (count_r < COUNT_W'(2)) || (newest_ts_r == rd_sample.ts);
    end
    if (state_r == wtm_pkg::S_MUL_A) begin
      prod_r <= {dpos_r, {wtm_pkg::MS_SHIFT_HI{1'b0}}} -
                {{(wtm_pkg::RATE_W - wtm_pkg::POS_W - wtm_pkg::MS_SHIFT_MID){1'b0}},
                 dpos_r, {wtm_pkg::MS_SHIFT_MID{1'b0}}};
    end
    if (state_r == wtm_pkg::S_MUL_B) begin
      prod_r <= prod_r -
                {{(wtm_pkg::RATE_W - wtm_pkg::POS_W - wtm_pkg::MS_SHIFT_LO){1'b0}},
                 dpos_r, {wtm_pkg::MS_SHIFT_LO{1'b0}}};
    end
  end

  wtm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (dtime_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rate_r       <= zero_r ? '0 : div_q;
      out_stored_r <= stored_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(wtm_pkg::OUT_TDATA_W - wtm_pkg::RATE_W){1'b0}}, rate_r};
  assign out_tuser  = out_stored_r;

  `WTM_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= COUNT_W'(DEPTH))
  `WTM_ASSERT_IMP(a_slot_bound, clk, rst_n, 1'b1, newest_slot_r <= SLOT_W'(DEPTH - 1))
  `WTM_ASSERT_NXT(a_accept_decide, clk, rst_n, in_accept, state_r == wtm_pkg::S_DECIDE)
  `WTM_ASSERT_IMP(a_div_in_div, clk, rst_n, div_busy, state_r == wtm_pkg::S_DIV)

endmodule

// ===== tb/windowed_throughput_meter_test.sv =====
// Self-checking testbench for the windowed throughput meter: directed and random traffic.
`timescale 1ns / 1ps

module windowed_throughput_meter_test;

  localparam int RING_DEPTH  = 16;
  localparam int TS_W        = wtm_pkg::TS_W;
  localparam int POS_W       = wtm_pkg::POS_W;
  localparam int RATE_W      = wtm_pkg::RATE_W;
  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASE_ITEMS = 105;

  // Expected result of one transaction
  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              stored;
  } meter_result_t;

  // Keeps its own copy of the sample ring and predicts the rate per transaction
  class rate_scoreboard;
    logic [TS_W-1:0]              ring_ts [RING_DEPTH];
    logic [POS_W-1:0]             ring_pos [RING_DEPTH];
    int                           newest_slot;
    int                           fill_count;
    logic [wtm_pkg::INTERVAL_W-1:0] interval_ms;
    meter_result_t                pending_results [$];
    int                           errors;

    function new();
      interval_ms = wtm_pkg::INTERVAL_RESET;
      newest_slot = 0;
      fill_count  = 0;
      errors      = 0;
      foreach (ring_ts[i]) begin
        ring_ts[i]  = '0;
        ring_pos[i] = '0;
      end
    endfunction

    function void set_interval(logic [wtm_pkg::INTERVAL_W-1:0] value);
      interval_ms = value;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Accepted input: update the ring and queue the predicted result
    function void note_sample(logic [TS_W-1:0] ts, logic [POS_W-1:0] pos);
      logic [TS_W-1:0]  elapsed;
      logic [TS_W-1:0]  dtime;
      logic [POS_W-1:0] dpos;
      logic [63:0]      scaled;
      int               slot;
      int               oldest;
      meter_result_t    res;
      slot       = newest_slot;
      res.stored = 1'b1;
      res.rate   = '0;
      // first sample always goes in; later ones need the interval to have passed
      if (fill_count != 0) begin
        elapsed = ts - ring_ts[slot];
        if (elapsed < {32'd0, interval_ms}) res.stored = 1'b0;
        else slot = (slot + 1) % RING_DEPTH;
      end
      if (res.stored) begin
        newest_slot    = slot;
        ring_ts[slot]  = ts;
        ring_pos[slot] = pos;
        if (fill_count < RING_DEPTH) fill_count++;
      end
      // rate over the valid window; zero with too few samples or no time span
      if (fill_count >= 2) begin
        oldest = (newest_slot + RING_DEPTH - fill_count + 1) % RING_DEPTH;
        dpos   = ring_pos[newest_slot] - ring_pos[oldest];
        dtime  = ring_ts[newest_slot] - ring_ts[oldest];
        if (dtime != '0) begin
          scaled   = {16'd0, dpos} * 64'd1000;
          res.rate = RATE_W'(scaled / {16'd0, dtime});
        end
      end
      pending_results.push_back(res);
    endfunction

    // Accepted result: compare against the oldest prediction
    function void check_result(logic [RATE_W-1:0] rate, logic stored);
      meter_result_t exp_res;
      if (pending_results.size() == 0) begin
        $error("unexpected result: rate_bytes_per_sec %0d, sample_stored %0d", rate, stored);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (rate !== exp_res.rate) begin
          $error("rate_bytes_per_sec: expected %0d, actual %0d", exp_res.rate, rate);
          errors++;
        end
        if (stored !== exp_res.stored) begin
          $error("sample_stored: expected %0d, actual %0d", exp_res.stored, stored);
          errors++;
        end
      end
    endfunction
  endclass

  logic                                 clk = 1'b0;
  logic                                 rst_n;
  logic                                 cfg_wr_en;
  logic [wtm_pkg::INTERVAL_W-1:0]       cfg_wr_data;
  logic                                 in_tvalid;
  logic                                 in_tready;
  logic [wtm_pkg::IN_TDATA_W-1:0]       in_tdata;   // timestamp_ms, position
  logic                                 out_tvalid;
  logic                                 out_tready;
  logic [wtm_pkg::OUT_TDATA_W-1:0]      out_tdata;  // rate_bytes_per_sec, zero pad
  logic                                 out_tuser;  // sample_stored

  rate_scoreboard meter_sb;
  int             cycle_count = 0;
  bit             hold_off_req = 1'b0;
  bit             send_quiet = 1'b0;
  bit             recv_quiet = 1'b0;
  logic [TS_W-1:0]  cur_ts;
  logic [POS_W-1:0] cur_pos;

  windowed_throughput_meter #(
    .DEPTH(RING_DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Both channels observed at the edge: results checked, inputs predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) meter_sb.check_result(out_tdata[RATE_W-1:0], out_tuser);
      if (in_tvalid && in_tready)
        meter_sb.note_sample(in_tdata[TS_W-1:0], in_tdata[TS_W+POS_W-1:TS_W]);
    end
  end

  // Idle cycles before a transaction; quiet stretches have none
  function automatic int pick_gap(inout bit quiet);
    if ($urandom_range(0, 11) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Result side: random stalls, and one long hold-off on request
  initial begin
    int gap;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = pick_gap(recv_quiet);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = LONG_HOLD;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // One transaction on the input channel, after a random gap
  task automatic send_item(input logic [TS_W-1:0] ts, input logic [POS_W-1:0] pos);
    int gap;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pos, ts};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering and wait until every predicted result has come back;
  // the wait starts once the last accepted transaction has been noted
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (meter_sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_interval(input logic [wtm_pkg::INTERVAL_W-1:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    meter_sb.set_interval(value);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly well-formed progress around the interval, with some noise
  task automatic run_phase(input int unsigned interval, input int count, input bit long_hold);
    int               kind;
    logic [TS_W-1:0]  step;
    write_interval(interval[wtm_pkg::INTERVAL_W-1:0]);
    if (long_hold) hold_off_req = 1'b1;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        // arbitrary jump in time and position
        cur_ts  = rand48();
        cur_pos = rand48();
      end else if (kind < 10) begin
        // timestamp steps backwards
        cur_ts = cur_ts - TS_W'($urandom_range(1, 5000));
      end else begin
        case ($urandom_range(0, 7))
          0:       step = '0;
          1:       step = TS_W'(interval);
          2:       step = (interval > 0) ? TS_W'(interval - 1) : '0;
          3, 4, 5: step = TS_W'($urandom_range(0, 2 * interval + 2));
          6:       step = TS_W'($urandom_range(0, interval / 4 + 1));
          default: step = TS_W'($urandom);
        endcase
        cur_ts = cur_ts + step;
        if ($urandom_range(0, 4) == 0) cur_pos = cur_pos + (rand48() >> 8);
        else cur_pos = cur_pos + POS_W'($urandom_range(0, 1 << 20));
      end
      send_item(cur_ts, cur_pos);
    end
  endtask

  // Main sequence
  initial begin
    logic [TS_W-1:0] span_ts;
    meter_sb    = new();
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset interval: first sample, wrap of time and position, backward step
    send_item({TS_W{1'b1}}, {POS_W{1'b1}});
    send_item('0, '0);
    send_item(48'd999, 48'd5);
    send_item(48'd1998, 48'h7FFF_FFFF_FFFF);
    send_item(48'd1999, {POS_W{1'b1}});
    send_item(48'd1, 48'd1000);

    // Interval zero: every item stored; window ends where it began in time
    write_interval('0);
    span_ts = 48'h0000_1234_5678;
    send_item(span_ts, '0);
    for (int i = 0; i < RING_DEPTH - 2; i++) send_item(rand48(), rand48());
    send_item(span_ts, rand48());

    // Random phases over several intervals, extremes included
    cur_ts  = rand48();
    cur_pos = rand48();
    run_phase(65535, PHASE_ITEMS, 1'b0);
    run_phase(1, PHASE_ITEMS, 1'b0);
    run_phase(0, PHASE_ITEMS, 1'b1);
    run_phase($urandom_range(2, 65534), PHASE_ITEMS, 1'b0);
    run_phase(1000, PHASE_ITEMS, 1'b0);
    run_phase($urandom_range(2, 50), PHASE_ITEMS, 1'b0);

    drain();
    repeat (100) @(posedge clk);
    if (meter_sb.errors == 0 && meter_sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
